@@ hw/rtl/pmw_pkg.sv @@
// Shared constants, codes and state type of the page map walker.
`default_nettype none

package pmw_pkg;

  localparam int POOL_PAGES    = 16;
  localparam int TABLE_ENTRIES = 512;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W  = $clog2(POOL_PAGES);
  localparam int NFS_W   = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W  = SLOT_W + IDX_W;
  localparam int DEPTH   = POOL_PAGES * TABLE_ENTRIES;
  localparam int DATA_W  = 48;
  localparam int FRAME_W = 36;
  localparam int WORD_W  = NFS_W + DATA_W;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  typedef enum logic [2:0] {
    ST_MAPPED      = 3'd0,
    ST_SAME_LARGE  = 3'd1,
    ST_MISALIGNED  = 3'd2,
    ST_LARGE_ABOVE = 3'd3,
    ST_EXHAUSTED   = 3'd4,
    ST_CONFLICT    = 3'd5,
    ST_OUTSIDE     = 3'd6
  } pmw_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_PTE,
    S_DONE
  } pmw_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/pmw_ifs.sv @@
// Valid/ready channel interfaces of the page map walker.
`default_nettype none

interface pmw_req_if;
  logic        valid;
  logic        ready;
  logic [47:0] vaddr;
  logic [47:0] paddr;
  logic [11:0] flags;
  modport source (output valid, vaddr, paddr, flags, input ready);
  modport sink (input valid, vaddr, paddr, flags, output ready);
endinterface

interface pmw_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       invalidate;
  modport source (output valid, status, invalidate, input ready);
  modport sink (input valid, status, invalidate, output ready);
endinterface

interface pmw_cfg_if;
  logic        valid;
  logic        ready;
  logic [35:0] pool_base_frame;
  modport source (output valid, pool_base_frame, input ready);
  modport sink (input valid, pool_base_frame, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/four_level_page_map_walker_unit.sv @@
// Top level of the four-level page map walker: table memory, walk sequencer, result register.
`default_nettype none

// Installs 4 KiB translations in a four-level radix page map held in an on-chip table
// memory of POOL_PAGES table pages of 512 entries each; slot zero is the root table and
// further tables come from a bump allocator that never reuses a slot. After reset the
// block runs a clearing pass over all POOL_PAGES * 512 entries (8192 as configured) and takes no
// map request until it ends; configuration writes are taken throughout. A request is first
// taken in; when misaligned it goes straight to loading the result register, and a full walk
// has a read and an evaluate step for each of the three upper levels, then writes the
// last-level entry and loads the result register. The walk is serialised by the single
// read port of the table memory, whose registered read lies on the dependency from
// each level's entry to the next level's address. A finished result waits in the output
// register, and a new request is taken while it waits.
module four_level_page_map_walker_unit (
  input  wire        clk,
  input  wire        rst_n,
  pmw_req_if.sink    in_ch,
  pmw_rsp_if.source  out_ch,
  pmw_cfg_if.sink    cfg_ch
);

  // Each memory word holds the entry in its low 48 bits and, above them, the allocator
  // count at the time of the write. A word in slot s written while the count was at or
  // below s was written before that slot was handed out, and the model clears a slot when
  // it hands it out; such a word therefore reads as zero once the count has passed s.
  // This replaces the clearing sweep on allocation.
  logic [pmw_pkg::WORD_W-1:0] mem [pmw_pkg::DEPTH];

  pmw_pkg::pmw_state_t state_r, state_nxt;

  logic [pmw_pkg::FRAME_W-1:0] base_r;
  logic [pmw_pkg::NFS_W-1:0]   nfs_r, nfs_nxt;
  logic [pmw_pkg::ADDR_W-1:0]  clr_r, clr_nxt;
  logic [pmw_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [1:0]                  level_r, level_nxt;
  logic [47:0]                 va_r, va_nxt;
  logic [47:0]                 pa_r, pa_nxt;
  logic [11:0]                 fl_r, fl_nxt;
  pmw_pkg::pmw_status_t        res_r, res_nxt;
  logic [pmw_pkg::WORD_W-1:0]  rd_word_r;

  logic                        out_valid_r, out_valid_nxt;
  pmw_pkg::pmw_status_t        out_status_r, out_status_nxt;
  logic                        out_inv_r, out_inv_nxt;

  logic                        in_xfer;
  logic                        misaligned;
  logic [pmw_pkg::IDX_W-1:0]   lvl_idx;
  logic [pmw_pkg::ADDR_W-1:0]  pos;
  logic [pmw_pkg::NFS_W-1:0]   slot_ext;
  logic [pmw_pkg::NFS_W-1:0]   rd_stamp;
  logic                        rd_visible;
  logic [pmw_pkg::DATA_W-1:0]  ent;
  logic [pmw_pkg::FRAME_W-1:0] rel;
  logic [pmw_pkg::FRAME_W-1:0] new_frame;
  logic                        pool_full;

  // Decisions of the evaluate cycle.
  logic                        ev_stop;
  logic                        ev_alloc;
  logic                        ev_follow;
  pmw_pkg::pmw_status_t        ev_status;

  logic                        mem_we;
  logic [pmw_pkg::ADDR_W-1:0]  mem_waddr;
  logic [pmw_pkg::WORD_W-1:0]  mem_wdata;
  logic                        mem_re;

  assign in_ch.ready       = (state_r == pmw_pkg::S_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.invalidate = out_inv_r;

  assign misaligned = (in_ch.vaddr[11:0] != 12'd0) || (in_ch.paddr[11:0] != 12'd0);

  // Table index for the level being walked: bits 47..39, 38..30, 29..21, 20..12.
  always_comb begin
    case (level_r)
      2'd0:    lvl_idx = va_r[47:39];
      2'd1:    lvl_idx = va_r[38:30];
      2'd2:    lvl_idx = va_r[29:21];
      default: lvl_idx = va_r[20:12];
    endcase
  end

  assign pos        = {slot_r, lvl_idx};
  assign slot_ext   = pmw_pkg::NFS_W'(slot_r);
  assign rd_stamp   = rd_word_r[pmw_pkg::WORD_W-1 -: pmw_pkg::NFS_W];
  assign rd_visible = (slot_ext < rd_stamp) || (slot_ext >= nfs_r);
  assign ent        = rd_visible ? rd_word_r[pmw_pkg::DATA_W-1:0] : '0;
  assign rel        = ent[47:12] - base_r;
  assign new_frame  = base_r + pmw_pkg::FRAME_W'(nfs_r);
  assign pool_full  = (nfs_r >= pmw_pkg::NFS_W'(pmw_pkg::POOL_PAGES));

  // Evaluate the entry that has just been read.
  always_comb begin
    ev_stop   = 1'b0;
    ev_alloc  = 1'b0;
    ev_follow = 1'b0;
    ev_status = pmw_pkg::ST_MAPPED;
    if (ent[pmw_pkg::BIT_PRESENT] && ent[pmw_pkg::BIT_LARGE]) begin
      ev_stop = 1'b1;
      if (level_r != 2'd2) begin
        ev_status = pmw_pkg::ST_LARGE_ABOVE;
      end else if ({ent[47:21], va_r[20:0]} == pa_r) begin
        ev_status = pmw_pkg::ST_SAME_LARGE;
      end else begin
        ev_status = pmw_pkg::ST_CONFLICT;
      end
    end else if (ent[pmw_pkg::BIT_PRESENT]) begin
      if (rel >= pmw_pkg::FRAME_W'(pmw_pkg::POOL_PAGES)) begin
        ev_stop   = 1'b1;
        ev_status = pmw_pkg::ST_OUTSIDE;
      end else begin
        ev_follow = 1'b1;
      end
    end else if (pool_full) begin
      ev_stop   = 1'b1;
      ev_status = pmw_pkg::ST_EXHAUSTED;
    end else begin
      ev_alloc = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmw_pkg::S_CLEAR: begin
        if (clr_r == pmw_pkg::ADDR_W'(pmw_pkg::DEPTH - 1)) begin
          state_nxt = pmw_pkg::S_IDLE;
        end
      end
      pmw_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = misaligned ? pmw_pkg::S_DONE : pmw_pkg::S_RD;
        end
      end
      pmw_pkg::S_RD: begin
        state_nxt = pmw_pkg::S_EVAL;
      end
      pmw_pkg::S_EVAL: begin
        if (ev_stop) begin
          state_nxt = pmw_pkg::S_DONE;
        end else if (level_r == 2'd2) begin
          state_nxt = pmw_pkg::S_PTE;
        end else begin
          state_nxt = pmw_pkg::S_RD;
        end
      end
      pmw_pkg::S_PTE: begin
        state_nxt = pmw_pkg::S_DONE;
      end
      pmw_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = pmw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pmw_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result register.
  always_comb begin
    nfs_nxt        = nfs_r;
    clr_nxt        = clr_r;
    slot_nxt       = slot_r;
    level_nxt      = level_r;
    va_nxt         = va_r;
    pa_nxt         = pa_r;
    fl_nxt         = fl_r;
    res_nxt        = res_r;
    mem_we         = 1'b0;
    mem_waddr      = pos;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_inv_nxt    = out_inv_r;
    case (state_r)
      pmw_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
      end
      pmw_pkg::S_IDLE: begin
        if (in_xfer) begin
          va_nxt    = in_ch.vaddr;
          pa_nxt    = in_ch.paddr;
          fl_nxt    = in_ch.flags;
          slot_nxt  = '0;
          level_nxt = 2'd0;
          res_nxt   = pmw_pkg::ST_MISALIGNED;
        end
      end
      pmw_pkg::S_RD: begin
        mem_re = 1'b1;
      end
      pmw_pkg::S_EVAL: begin
        if (ev_stop) begin
          res_nxt = ev_status;
        end else begin
          level_nxt = level_r + 2'd1;
          if (ev_follow) begin
            slot_nxt = rel[pmw_pkg::SLOT_W-1:0];
          end
        end
        if (ev_alloc) begin
          // Link a fresh table: frame of the next free slot, flags and present bit. The
          // link is stamped with the count after this allocation, since the table that
          // holds it may itself be the slot being handed out, and the link must outlive
          // that slot's clearing.
          mem_we    = 1'b1;
          mem_wdata = {nfs_r + pmw_pkg::NFS_W'(1), new_frame, fl_r | 12'h001};
          nfs_nxt   = nfs_r + 1'b1;
          slot_nxt  = nfs_r[pmw_pkg::SLOT_W-1:0];
        end
      end
      pmw_pkg::S_PTE: begin
        // The physical address is aligned, so its low bits carry the flags.
        mem_we    = 1'b1;
        mem_wdata = {nfs_r, pa_r[47:12], fl_r | 12'h001};
        res_nxt   = pmw_pkg::ST_MAPPED;
      end
      pmw_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_inv_nxt    = (res_r == pmw_pkg::ST_MAPPED) || (res_r == pmw_pkg::ST_SAME_LARGE);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmw_pkg::S_CLEAR;
      nfs_r       <= pmw_pkg::NFS_W'(1);
      clr_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nfs_r       <= nfs_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        base_r <= cfg_ch.pool_base_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    level_r      <= level_nxt;
    va_r         <= va_nxt;
    pa_r         <= pa_nxt;
    fl_r         <= fl_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_inv_r    <= out_inv_nxt;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_word_r <= mem[pos];
    end
  end

  // The invalidate mark follows the status of the same result.
  a_inv_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_inv_r == ((out_status_r == pmw_pkg::ST_MAPPED) ||
                                   (out_status_r == pmw_pkg::ST_SAME_LARGE))))
    else $error("invalidate mark does not match status");

  // The allocator never passes the pool size and never goes back.
  a_nfs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (nfs_r <= pmw_pkg::NFS_W'(pmw_pkg::POOL_PAGES)) && (nfs_r >= $past(nfs_r)))
    else $error("allocator count out of range or decreasing");

  // A new table link is only written while the pool still has a free slot.
  a_link_in_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmw_pkg::S_EVAL && mem_we) |-> !pool_full)
    else $error("table link written with the pool exhausted");

  // Reading and writing the memory never coincide during a walk.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> !mem_we)
    else $error("table memory read and write in the same cycle");

endmodule

`default_nettype wire
